// ===== hdl/union_find_kruskal_engine_macros.svh =====
// Assertion macros used by the union-find engine checker.
`ifndef UNION_FIND_KRUSKAL_ENGINE_MACROS_SVH
`define UNION_FIND_KRUSKAL_ENGINE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define UFK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, built on the implication form.
`define UFK_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    `UFK_ASSERT_IMP(label, clk, rst_n, 1'b1, cond, msg)

`endif

// ===== hdl/ufk_pkg.sv =====
// Types, constants and helpers for the union-find Kruskal engine.
`timescale 1ns / 1ps
package ufk_pkg;

    localparam int NODES    = 1024;
    localparam int NODE_W   = 10;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int STEP_W   = ADDR_W + 1;
    localparam int RANK_W   = 4;
    localparam int WEIGHT_W = 32;
    localparam int COST_W   = 48;

    localparam logic [RANK_W-1:0] RANK_MAX         = '1;
    localparam logic [NODE_W-1:0] MERGE_MAX        = '1;
    localparam logic [COST_W-1:0] COST_MAX         = '1;
    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = '1;
    localparam logic [STEP_W-1:0] STEP_LIMIT       = STEP_W'(NODES);
    localparam logic [ADDR_W-1:0] LAST_ADDR        = ADDR_W'(NODES - 1);

    localparam logic ACT_UNITE = 1'b0;
    localparam logic ACT_FIND  = 1'b1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ADDR_W-1:0] parent;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_NEXT,
        ST_LINK,
        ST_RANK,
        ST_REFIND
    } state_t;

    // Which root search is running.
    typedef enum logic [1:0] {
        PASS_A,
        PASS_B,
        PASS_OUT
    } pass_t;

    function automatic logic in_table(input logic [NODE_W-1:0] n);
        return 32'(n) < 32'(NODES);
    endfunction

endpackage

// ===== hdl/union_find_kruskal_engine.sv =====
// Union-find Kruskal engine: sequencer around one parent/rank RAM.
// Sequence: a find walks node_a to its root and compresses the path; an edge searches node_a
//   and node_b, links differing roots by rank and then searches node_a again for the result.
// Flow: one transaction at a time; the next is taken at the earliest at the edge that ends the
//   done cycle. The receiver cannot stall.
// Reset: busy stays high during a clearing pass that loads the table.
`timescale 1ns / 1ps
module union_find_kruskal_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [ufk_pkg::NODE_W-1:0]   node_a,
    input  logic [ufk_pkg::NODE_W-1:0]   node_b,
    input  logic [ufk_pkg::WEIGHT_W-1:0] edge_weight,
    // result channel
    output logic                         done,
    output logic                         merged,
    output logic [ufk_pkg::NODE_W-1:0]   root_index,
    output logic [ufk_pkg::NODE_W-1:0]   component_total,
    output logic [ufk_pkg::COST_W-1:0]   cost_total,
    // configuration write channel (node_count)
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ufk_pkg::NODE_W-1:0]   cfg_data
);

    import ufk_pkg::*;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    pass_t               pass_reg, pass_next;
    logic                done_reg, done_next;
    logic                merged_reg, merged_next;
    logic [NODE_W-1:0]   merge_count_reg, merge_count_next;
    logic [COST_W-1:0]   cost_sum_reg, cost_sum_next;
    logic [NODE_W-1:0]   node_count_reg;
    logic [ADDR_W-1:0]   clr_reg, clr_next;

    // Item payload and walk registers
    logic [ADDR_W-1:0]   a_reg, a_next;
    logic [ADDR_W-1:0]   b_reg, b_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [ADDR_W-1:0]   x_reg, x_next;          // node being compressed / start
    logic [ADDR_W-1:0]   r_reg, r_next;          // current walk position, then root
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [RANK_W-1:0]   root_rank_reg, root_rank_next;
    logic [ADDR_W-1:0]   ra_reg, ra_next;        // root of node_a from the first search
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [NODE_W-1:0]   root_out_reg, root_out_next;

    // RAM port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_wr_addr;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [$bits(entry_t)-1:0] ram_rd_raw;
    entry_t              rd_word;

    logic [STEP_W-1:0]   step_inc;
    logic [COST_W:0]     cost_wide;
    logic                need_walk;

    assign rd_word   = entry_t'(ram_rd_raw);
    assign step_inc  = steps_reg + 1'b1;
    assign cost_wide = {1'b0, cost_sum_reg} + (COST_W + 1)'(weight_reg);

    // An edge needs both ends inside the table; a find only node_a.
    assign need_walk = in_table(node_a) && ((action == ACT_FIND) || in_table(node_b));

    // Parent and rank share one word so compression keeps the rank intact.
    ufk_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NODES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            pass_reg        <= PASS_A;
            done_reg        <= 1'b0;
            merged_reg      <= 1'b0;
            merge_count_reg <= '0;
            cost_sum_reg    <= '0;
            node_count_reg  <= NODE_COUNT_RESET;
            clr_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_reg        <= pass_next;
            done_reg        <= done_next;
            merged_reg      <= merged_next;
            merge_count_reg <= merge_count_next;
            cost_sum_reg    <= cost_sum_next;
            clr_reg         <= clr_next;
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        weight_reg    <= weight_next;
        x_reg         <= x_next;
        r_reg         <= r_next;
        steps_reg     <= steps_next;
        root_rank_reg <= root_rank_next;
        ra_reg        <= ra_next;
        rank_a_reg    <= rank_a_next;
        root_out_reg  <= root_out_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        done_next        = 1'b0;
        merged_next      = merged_reg;
        merge_count_next = merge_count_reg;
        cost_sum_next    = cost_sum_reg;
        clr_next         = clr_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        weight_next      = weight_reg;
        x_next           = x_reg;
        r_next           = r_reg;
        steps_next       = steps_reg;
        root_rank_next   = root_rank_reg;
        ra_next          = ra_reg;
        rank_a_next      = rank_a_reg;
        root_out_next    = root_out_reg;

        ram_we           = 1'b0;
        ram_wr_addr      = x_reg;
        ram_wr_data      = '{rank: rd_word.rank, parent: r_reg};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = x_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // every node starts as its own root with rank zero
                ram_we      = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '{rank: '0, parent: clr_reg};
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    a_next        = ADDR_W'(node_a);
                    b_next        = ADDR_W'(node_b);
                    weight_next   = edge_weight;
                    merged_next   = 1'b0;
                    if (need_walk)
                    begin
                        x_next      = ADDR_W'(node_a);
                        r_next      = ADDR_W'(node_a);
                        steps_next  = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(node_a);
                        pass_next   = (action == ACT_FIND) ? PASS_OUT : PASS_A;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        // node outside the table: answer at once
                        root_out_next = node_a;
                        done_next     = 1'b1;
                    end
                end
            end

            ST_WALK:
            begin
                // rd_word is the entry of r_reg
                if ((rd_word.parent == r_reg) || (steps_reg == STEP_LIMIT))
                begin
                    root_rank_next = rd_word.rank;
                    steps_next     = '0;
                    if (x_reg == r_reg)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = x_reg;
                        state_next  = ST_COMP;
                    end
                end
                else
                begin
                    r_next      = rd_word.parent;
                    steps_next  = step_inc;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_word.parent;
                end
            end

            ST_COMP:
            begin
                // point x at the root, fetch its old parent in the same cycle
                ram_we      = 1'b1;
                ram_wr_addr = x_reg;
                ram_wr_data = '{rank: rd_word.rank, parent: r_reg};
                x_next      = rd_word.parent;
                steps_next  = step_inc;
                if ((rd_word.parent != r_reg) && (step_inc < STEP_LIMIT))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_word.parent;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                unique case (pass_reg)
                    PASS_A:
                    begin
                        ra_next     = r_reg;
                        rank_a_next = root_rank_reg;
                        x_next      = b_reg;
                        r_next      = b_reg;
                        steps_next  = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = b_reg;
                        pass_next   = PASS_B;
                        state_next  = ST_WALK;
                    end
                    PASS_B:
                    begin
                        state_next = (r_reg == ra_reg) ? ST_REFIND : ST_LINK;
                    end
                    PASS_OUT:
                    begin
                        root_out_next = NODE_W'(r_reg);
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                endcase
            end

            ST_LINK:
            begin
                // r_reg / root_rank_reg hold the root of node_b
                ram_we      = 1'b1;
                merged_next = 1'b1;
                if (merge_count_reg != MERGE_MAX)
                begin
                    merge_count_next = merge_count_reg + 1'b1;
                end
                cost_sum_next = cost_wide[COST_W] ? COST_MAX : cost_wide[COST_W-1:0];
                if (rank_a_reg < root_rank_reg)
                begin
                    ram_wr_addr = ra_reg;
                    ram_wr_data = '{rank: rank_a_reg, parent: r_reg};
                    state_next  = ST_REFIND;
                end
                else
                begin
                    ram_wr_addr = r_reg;
                    ram_wr_data = '{rank: root_rank_reg, parent: ra_reg};
                    state_next  = (rank_a_reg == root_rank_reg) ? ST_RANK : ST_REFIND;
                end
            end

            ST_RANK:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ra_reg;
                ram_wr_data = '{rank: (rank_a_reg == RANK_MAX) ? RANK_MAX
                                                               : rank_a_reg + 1'b1,
                                parent: ra_reg};
                state_next  = ST_REFIND;
            end

            ST_REFIND:
            begin
                // final search of node_a, issued after any link write has landed
                x_next      = a_reg;
                r_next      = a_reg;
                steps_next  = '0;
                ram_rd_en   = 1'b1;
                ram_rd_addr = a_reg;
                pass_next   = PASS_OUT;
                state_next  = ST_WALK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign busy            = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign merged          = merged_reg;
    assign root_index      = root_out_reg;
    assign cost_total      = cost_sum_reg;
    assign component_total = (node_count_reg > merge_count_reg)
                             ? node_count_reg - merge_count_reg : '0;

endmodule

// ===== hdl/ufk_ram.sv =====
// Generic simple dual-port RAM, read-first, registered read.
`timescale 1ns / 1ps
module ufk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ufk_checker.sv =====
// Port-level checker for the union-find engine, bound to the top level.
`timescale 1ns / 1ps
`include "union_find_kruskal_engine_macros.svh"
module ufk_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       busy,
    input logic                       done,
    input logic                       merged,
    input logic [ufk_pkg::COST_W-1:0] cost_total
);

    import ufk_pkg::*;

    logic [COST_W-1:0] cost_seen;

    assign cost_seen = cost_total;

    // saturating total never goes down
    `UFK_ASSERT_ALWAYS(a_cost_mono, clk, rst_n, cost_seen >= $past(cost_seen), "cost fell")
    // a non-merging transaction leaves the total alone
    `UFK_ASSERT_IMP(a_cost_hold, clk, rst_n, done && !merged, $stable(cost_seen), "cost moved")
    // a merge needs table walks, so the engine was busy just before
    `UFK_ASSERT_IMP(a_merge_busy, clk, rst_n, done && merged, $past(busy), "merge without work")

endmodule

bind union_find_kruskal_engine ufk_checker u_ufk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .merged     (merged),
    .cost_total (cost_total)
);

// ===== tb/union_find_kruskal_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the union-find Kruskal engine: table-driven and random MST traffic.
module union_find_kruskal_engine_tb;
    import ufk_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYC   = 5;
    // Worst correct run: the clearing pass, then ~1100 items (three searches on
    // depth-10 trees each) with random sender gaps, plus the drains between
    // phases. The limit is far above such a run.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 80;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 215;
    localparam int DIR_ROWS    = 19;

    typedef struct packed {
        logic              merged;
        logic [NODE_W-1:0] root;
        logic [NODE_W-1:0] comp;
        logic [COST_W-1:0] cost;
    } mst_result_t;

    typedef struct packed {
        logic                act;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        logic                known;   // typed-in expectation below, else predicted
        mst_result_t         want;
    } stim_row_t;

    localparam mst_result_t NO_RES = '0;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                action      = ACT_UNITE;
    logic [NODE_W-1:0]   node_a      = '0;
    logic [NODE_W-1:0]   node_b      = '0;
    logic [WEIGHT_W-1:0] edge_weight = '0;
    logic                cfg_valid   = 1'b0;
    logic [NODE_W-1:0]   cfg_data    = '0;
    logic                busy;
    logic                done;
    logic                merged;
    logic [NODE_W-1:0]   root_index;
    logic [NODE_W-1:0]   component_total;
    logic [COST_W-1:0]   cost_total;
    logic                cfg_ready;

    // Shadow disjoint-set forest and running MST totals
    logic [ADDR_W-1:0]   up_link   [NODES];
    logic [RANK_W-1:0]   tree_rank [NODES];
    logic [NODE_W-1:0]   joins_done;
    logic [COST_W-1:0]   span_cost;
    logic [NODE_W-1:0]   vertex_count;

    mst_result_t         mst_results_due[$];
    stim_row_t           dir_rows [DIR_ROWS];
    int                  fault_count = 0;
    int                  idle_pct    = 0;
    int unsigned         cycle_count = 0;

    union_find_kruskal_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .node_a          (node_a),
        .node_b          (node_b),
        .edge_weight     (edge_weight),
        .done            (done),
        .merged          (merged),
        .root_index      (root_index),
        .component_total (component_total),
        .cost_total      (cost_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Root search with full path compression; every walk is bounded.
    function automatic logic [ADDR_W-1:0] chase_root(input logic [ADDR_W-1:0] n);
        logic [ADDR_W-1:0] r;
        logic [ADDR_W-1:0] nxt;
        int                steps;
        r = n;
        steps = 0;
        while (up_link[r] != r && steps < NODES)
        begin
            r = up_link[r];
            steps++;
        end
        steps = 0;
        while (n != r && steps < NODES)
        begin
            nxt = up_link[n];
            up_link[n] = r;
            n = nxt;
            steps++;
        end
        return r;
    endfunction

    // One Kruskal step on the shadow forest: union by rank, saturating totals.
    function automatic mst_result_t kruskal_step(input logic act,
                                                 input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b,
                                                 input logic [WEIGHT_W-1:0] w);
        mst_result_t       res;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
        logic [COST_W:0]   sum;
        res = '0;
        res.root = a;
        if (act == ACT_UNITE)
        begin
            // nodes beyond the table make the edge a no-op
            if (32'(a) < NODES && 32'(b) < NODES)
            begin
                ra = chase_root(a);
                rb = chase_root(b);
                if (ra != rb)
                begin
                    if (tree_rank[ra] < tree_rank[rb])
                        up_link[ra] = rb;
                    else
                    begin
                        up_link[rb] = ra;
                        if (tree_rank[ra] == tree_rank[rb] && tree_rank[ra] != RANK_MAX)
                            tree_rank[ra] = tree_rank[ra] + 1'b1;
                    end
                    res.merged = 1'b1;
                    if (joins_done != MERGE_MAX)
                        joins_done = joins_done + 1'b1;
                    sum = {1'b0, span_cost} + (COST_W + 1)'(w);
                    span_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                end
                res.root = chase_root(a);
            end
        end
        else if (32'(a) < NODES)
            res.root = chase_root(a);
        res.comp = (vertex_count > joins_done) ? vertex_count - joins_done : '0;
        res.cost = span_cost;
        return res;
    endfunction

    // Present one command, wait for its transaction, then log what it must return.
    task automatic issue_item(input stim_row_t row);
        mst_result_t res;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= row.act;
        node_a      <= row.a;
        node_b      <= row.b;
        edge_weight <= row.w;
        do
            @(posedge clk);
        while (busy);
        res = kruskal_step(row.act, row.a, row.b, row.w);
        mst_results_due.push_back(row.known ? row.want : res);
    endtask

    // Hold off until every outstanding result is back, then let the engine settle.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (mst_results_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [NODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        vertex_count  = value;
    endtask

    // Results are sampled at the edge that closes the strobe cycle.
    always @(posedge clk)
    begin
        mst_result_t want;
        if (rst_n && done)
        begin
            if (mst_results_due.size() == 0)
            begin
                $error("result with nothing outstanding: root_index %0d", root_index);
                fault_count++;
            end
            else
            begin
                want = mst_results_due.pop_front();
                if (merged !== want.merged)
                begin
                    $error("merged: expected %0d, got %0d", want.merged, merged);
                    fault_count++;
                end
                if (root_index !== want.root)
                begin
                    $error("root_index: expected %0d, got %0d", want.root, root_index);
                    fault_count++;
                end
                if (component_total !== want.comp)
                begin
                    $error("component_total: expected %0d, got %0d",
                           want.comp, component_total);
                    fault_count++;
                end
                if (cost_total !== want.cost)
                begin
                    $error("cost_total: expected 0x%0h, got 0x%0h", want.cost, cost_total);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("union_find_kruskal_engine_tb: done, errors");
        $finish;
    end

    initial
    begin
        stim_row_t         row;
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] nodes_cfg;
        logic [WEIGHT_W-1:0] wt;
        int                span;
        int                burst;
        int                sent;
        int                ph;
        int                k;

        for (k = 0; k < NODES; k++)
        begin
            up_link[k]   = ADDR_W'(k);
            tree_rank[k] = '0;
        end
        joins_done   = '0;
        span_cost    = '0;
        vertex_count = NODE_COUNT_RESET;

        // Fresh forest: the first rows can be read straight off the reset state.
        dir_rows = '{
            '{ACT_FIND,  10'd0,    10'd1023, 32'hFFFF_FFFF, 1'b1,
               '{1'b0, 10'd0,    10'd1023, 48'd0}},
            '{ACT_FIND,  10'd1023, 10'd0,    32'h0000_0000, 1'b1,
               '{1'b0, 10'd1023, 10'd1023, 48'd0}},
            // extreme endpoints, largest weight
            '{ACT_UNITE, 10'd0,    10'd1023, 32'hFFFF_FFFF, 1'b1,
               '{1'b1, 10'd0,    10'd1022, 48'hFFFF_FFFF}},
            // same set, reversed endpoints
            '{ACT_UNITE, 10'd1023, 10'd0,    32'd5,         1'b1,
               '{1'b0, 10'd0,    10'd1022, 48'hFFFF_FFFF}},
            // self loop
            '{ACT_UNITE, 10'd5,    10'd5,    32'd7,         1'b1,
               '{1'b0, 10'd5,    10'd1022, 48'hFFFF_FFFF}},
            '{ACT_FIND,  10'd1023, 10'd0,    32'd0,         1'b1,
               '{1'b0, 10'd0,    10'd1022, 48'hFFFF_FFFF}},
            // zero weight merge
            '{ACT_UNITE, 10'd2,    10'd3,    32'd0,         1'b1,
               '{1'b1, 10'd2,    10'd1021, 48'hFFFF_FFFF}},
            // equal ranks, cost carries into bit 32
            '{ACT_UNITE, 10'd3,    10'd0,    32'd1,         1'b1,
               '{1'b1, 10'd2,    10'd1020, 48'h1_0000_0000}},
            // two-hop path gets compressed
            '{ACT_FIND,  10'd1023, 10'd1023, 32'd0,         1'b0, NO_RES},
            // lower rank hangs under higher, then the other way round
            '{ACT_UNITE, 10'd7,    10'd2,    32'd10,        1'b0, NO_RES},
            '{ACT_UNITE, 10'd2,    10'd9,    32'd11,        1'b0, NO_RES},
            '{ACT_UNITE, 10'h2AA,  10'h155,  32'hAAAA_AAAA, 1'b0, NO_RES},
            '{ACT_UNITE, 10'h155,  10'h2AA,  32'h5555_5555, 1'b0, NO_RES},
            '{ACT_UNITE, 10'h155,  10'd0,    32'hB000_0000, 1'b0, NO_RES},
            '{ACT_FIND,  10'h155,  10'h2AA,  32'h1234_5678, 1'b0, NO_RES},
            '{ACT_UNITE, 10'd512,  10'd511,  32'hC000_0000, 1'b0, NO_RES},
            '{ACT_FIND,  10'd0,    10'd0,    32'd0,         1'b0, NO_RES},
            '{ACT_FIND,  10'd3,    10'd1,    32'd0,         1'b0, NO_RES},
            '{ACT_UNITE, 10'd1022, 10'd1,    32'hFFFF_FFFF, 1'b0, NO_RES}
        };

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // directed part runs on the reset node count, no idling
        for (k = 0; k < DIR_ROWS; k++)
            issue_item(dir_rows[k]);

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       nodes_cfg = 10'd1;              // component count floors at 0
                1:       nodes_cfg = NODE_COUNT_RESET;
                3:       nodes_cfg = 10'd1;
                default: nodes_cfg = NODE_W'($urandom_range(2, 1022));
            endcase
            write_node_count(nodes_cfg);
            case (ph)
                1, 3:    idle_pct = 73;
                2:       idle_pct = 10;
                default: idle_pct = 0;
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(3) != 0)
                begin
                    // Kruskal burst: ascending weights inside a small node window,
                    // so merges, same-set rejects and deep paths all turn up
                    base  = NODE_W'($urandom_range(0, NODES - 1));
                    span  = $urandom_range(2, 24);
                    burst = $urandom_range(4, 16);
                    wt    = $urandom_range(0, 32'hFFFF_0000);
                    for (k = 0; k < burst; k++)
                    begin
                        row.act   = ($urandom_range(99) < 15) ? ACT_FIND : ACT_UNITE;
                        row.a     = NODE_W'(base + $urandom_range(0, span - 1));
                        row.b     = NODE_W'(base + $urandom_range(0, span - 1));
                        wt        = wt + $urandom_range(0, 4096);
                        row.w     = wt;
                        row.known = 1'b0;
                        row.want  = NO_RES;
                        issue_item(row);
                        sent++;
                    end
                end
                else
                begin
                    // noise: anything the fields allow, weight order ignored
                    row.act   = $urandom_range(1) ? ACT_FIND : ACT_UNITE;
                    row.a     = NODE_W'($urandom_range(0, NODES - 1));
                    row.b     = NODE_W'($urandom_range(0, NODES - 1));
                    row.w     = $urandom();
                    row.known = 1'b0;
                    row.want  = NO_RES;
                    issue_item(row);
                    sent++;
                end
                if ($urandom_range(49) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (fault_count == 0)
            $display("union_find_kruskal_engine_tb: done, clean");
        else
            $display("union_find_kruskal_engine_tb: done, errors");
        $finish;
    end

endmodule
